/* hw/rtl/pcls_pkg.sv */
// Shared constants, payload types and helpers for the per-class luma statistics block.
package pcls_pkg;

   // Store geometry. NUM_CLASSES may range from 2 to 256.
   localparam int NUM_CLASSES = 256;
   localparam int MAX_PIXELS  = 16777216;

   // Field widths.
   localparam int FUNC_W   = 3;
   localparam int CHAN_W   = 8;
   localparam int ID_W     = 8;
   localparam int LUMA_W   = 22;
   localparam int COUNT_W  = 25;
   localparam int SUM_W    = 46;
   localparam int CLASS_AW = $clog2(NUM_CLASSES);

   // Configuration port geometry.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Job queue between the front and the back; the depth is a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Saturation limit of every count, and the class id bound.
   localparam logic [COUNT_W-1:0] MAX_COUNT   = COUNT_W'(MAX_PIXELS);
   localparam logic [ID_W:0]      CLASS_LIMIT = (ID_W + 1)'(NUM_CLASSES);

   // Rec.709 luma weights, full scale 2550000.
   localparam logic [LUMA_W-1:0] LUMA_R = LUMA_W'(2126);
   localparam logic [LUMA_W-1:0] LUMA_G = LUMA_W'(7152);
   localparam logic [LUMA_W-1:0] LUMA_B = LUMA_W'(722);

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_PIXEL      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ_CLASS = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ_FRAME = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ_WATER = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IDS_ENABLED   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_WATER_ID  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_OVER_RED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_FLOOR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_SLACK   = 3'd4;

   // Register reset values.
   localparam logic [ID_W-1:0]   RST_FAR_WATER_ID  = 8'd200;
   localparam logic [CHAN_W-1:0] RST_BLUE_OVER_RED = 8'd6;
   localparam logic [CHAN_W-1:0] RST_BLUE_FLOOR    = 8'd22;
   localparam logic [CHAN_W-1:0] RST_GREEN_SLACK   = 8'd4;

   // Input beat.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [ID_W-1:0]   class_id;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [LUMA_W-1:0]  pixel_luma;
      logic               is_water;
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   luma_sum;
      logic [LUMA_W-1:0]  luma_max;
      logic [LUMA_W-1:0]  mean_luma;
   } rsp_type;

   // Classified job handed from the front to the back.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   class_id;
      logic [LUMA_W-1:0] luma;
      logic              water;
      logic              acc_class;
   } job_type;

   // True when a class id addresses a real class store entry.
   function automatic logic class_in_range(input logic [ID_W-1:0] id);
      return {1'b0, id} < CLASS_LIMIT;
   endfunction

endpackage

/* hw/rtl/per_class_luma_statistics.sv */
// Top level of the per-class luma statistics block: front end, job queue and back end.
// Every accepted beat gives one result, after any wait in the job queue: a pixel after the
// class store read-modify-write, a frame, water or class read after the mean divider.
// The back end takes a new job only when the last one is finished (class store read-modify-write
// for a pixel, mean divider for a read); busy is high while the 2-entry queue is full.
// Results cannot be stalled. Synchronous reset restores the registers and empties the stores.
module per_class_luma_statistics (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  pcls_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output pcls_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [pcls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcls_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic              push;
   pcls_pkg::job_type push_job;
   logic              pop;
   pcls_pkg::job_type head_job;
   logic              queue_empty;
   logic              queue_full;

   // Classification and luma.
   pcls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .queue_full (queue_full),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_job   (push_job)
   );

   // Job queue.
   pcls_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // Statistics stores and result generation.
   pcls_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   assign busy = queue_full;

endmodule

/* hw/rtl/pcls_front.sv */
// Front end: configuration registers, luma computation and water classification.
module pcls_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  pcls_pkg::req_type                   req_data,
   input  logic                                queue_full,
   input  logic                                csr_we,
   input  logic [pcls_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcls_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                push,
   output pcls_pkg::job_type                   push_job
);

   logic                              ids_enabled_ff;
   logic [pcls_pkg::ID_W-1:0]         far_water_id_ff;
   logic [pcls_pkg::CHAN_W-1:0]       blue_over_red_ff;
   logic [pcls_pkg::CHAN_W-1:0]       blue_floor_ff;
   logic [pcls_pkg::CHAN_W-1:0]       green_slack_ff;

   logic [pcls_pkg::LUMA_W-1:0]       luma;
   logic [pcls_pkg::CHAN_W:0]         red_plus_margin;
   logic [pcls_pkg::CHAN_W:0]         blue_plus_slack;
   logic                              blue_dom;
   logic                              open_id;
   logic                              far_id;

   // Configuration registers; the user must write them only while the block is idle, which the block leaves unenforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         ids_enabled_ff   <= 1'b1;
         far_water_id_ff  <= pcls_pkg::RST_FAR_WATER_ID;
         blue_over_red_ff <= pcls_pkg::RST_BLUE_OVER_RED;
         blue_floor_ff    <= pcls_pkg::RST_BLUE_FLOOR;
         green_slack_ff   <= pcls_pkg::RST_GREEN_SLACK;
      end else if (csr_we) begin
         case (csr_index)
            pcls_pkg::CSR_IDS_ENABLED:   ids_enabled_ff   <= csr_wdata[0];
            pcls_pkg::CSR_FAR_WATER_ID:  far_water_id_ff  <= csr_wdata;
            pcls_pkg::CSR_BLUE_OVER_RED: blue_over_red_ff <= csr_wdata;
            pcls_pkg::CSR_BLUE_FLOOR:    blue_floor_ff    <= csr_wdata;
            pcls_pkg::CSR_GREEN_SLACK:   green_slack_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Luma is three small constant multiplies and two adds.
   assign luma = pcls_pkg::LUMA_R * pcls_pkg::LUMA_W'(req_data.red)
               + pcls_pkg::LUMA_G * pcls_pkg::LUMA_W'(req_data.green)
               + pcls_pkg::LUMA_B * pcls_pkg::LUMA_W'(req_data.blue);

   // Blue dominance compares carry one extra bit so no sum wraps.
   assign red_plus_margin = {1'b0, req_data.red} + {1'b0, blue_over_red_ff};
   assign blue_plus_slack = {1'b0, req_data.blue} + {1'b0, green_slack_ff};
   assign blue_dom = ({1'b0, req_data.blue} >= red_plus_margin)
                   && (req_data.blue > blue_floor_ff)
                   && (blue_plus_slack >= {1'b0, req_data.green});
   assign open_id = !ids_enabled_ff || (req_data.class_id == '0);
   assign far_id  = ids_enabled_ff && (req_data.class_id == far_water_id_ff);

   // Every accepted beat becomes one job in the queue.
   assign push = start && !queue_full;

   always_comb begin
      push_job.func      = req_data.func;
      push_job.class_id  = req_data.class_id;
      push_job.luma      = luma;
      push_job.water     = far_id || (open_id && blue_dom);
      push_job.acc_class = ids_enabled_ff && pcls_pkg::class_in_range(req_data.class_id);
   end

endmodule

/* hw/rtl/pcls_queue.sv */
// Short job queue that decouples the front end from the statistics back end.
module pcls_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pcls_pkg::job_type push_job,
   input  logic              pop,
   output pcls_pkg::job_type head_job,
   output logic              empty,
   output logic              full
);

   pcls_pkg::job_type                entry_ff [pcls_pkg::QUEUE_DEPTH];
   logic [pcls_pkg::QUEUE_AW-1:0]    wr_ptr_ff;
   logic [pcls_pkg::QUEUE_AW-1:0]    rd_ptr_ff;
   logic [pcls_pkg::QUEUE_AW:0]      count_ff;

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (pcls_pkg::QUEUE_AW + 1)'(pcls_pkg::QUEUE_DEPTH));

   // The front never pushes into a full queue and the back never pops an empty one.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job queue underflow");

endmodule

/* hw/rtl/pcls_div.sv */
// Restoring divider, one quotient bit per cycle, for the mean of a luma sum.
module pcls_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pcls_pkg::SUM_W-1:0]       dividend,
   input  logic [pcls_pkg::COUNT_W-1:0]     divisor,
   output logic                             done,
   output logic [pcls_pkg::SUM_W-1:0]       quotient
);

   localparam int STEP_W = $clog2(pcls_pkg::SUM_W + 1);

   logic                              busy_ff;
   logic                              done_ff;
   logic [STEP_W-1:0]                 step_ff;
   logic [pcls_pkg::COUNT_W:0]        rem_ff;
   logic [pcls_pkg::SUM_W-1:0]        quo_ff;
   logic [pcls_pkg::COUNT_W-1:0]      dvs_ff;

   logic [pcls_pkg::COUNT_W:0]        rem_shift;
   logic                              fits;
   logic [pcls_pkg::COUNT_W:0]        rem_in;
   logic [pcls_pkg::SUM_W-1:0]        quo_in;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      rem_shift = {rem_ff[pcls_pkg::COUNT_W-1:0], quo_ff[pcls_pkg::SUM_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      rem_in    = fits ? rem_shift - {1'b0, dvs_ff} : rem_shift;
      quo_in    = {quo_ff[pcls_pkg::SUM_W-2:0], fits};
   end

   // Step control; done pulses for one cycle after the last step.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= !start && busy_ff && (step_ff == STEP_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(pcls_pkg::SUM_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath; the dividend shifts out of the quotient register as bits come in.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // A zero count gives a zero mean.
   assign done     = done_ff;
   assign quotient = (dvs_ff == '0) ? '0 : quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider finished without running");

endmodule

/* hw/rtl/pcls_back.sv */
// Back end: class store memory, frame and water totals, reads and clear.
module pcls_back (
   input  logic              clock,
   input  logic              reset,
   input  pcls_pkg::job_type head_job,
   input  logic              queue_empty,
   output logic              pop,
   output logic              rsp_valid,
   output pcls_pkg::rsp_type rsp_data
);

   typedef struct packed {
      logic [pcls_pkg::COUNT_W-1:0] count;
      logic [pcls_pkg::SUM_W-1:0]   sum;
      logic [pcls_pkg::LUMA_W-1:0]  max;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PIX_RD,
      ST_CLS_RD,
      ST_DIV
   } state_type;

   state_type                         state_ff;
   pcls_pkg::job_type                 job_ff;
   entry_type                         pend_ff;
   logic                              rsp_valid_ff;
   pcls_pkg::rsp_type                 rsp_data_ff;
   logic [pcls_pkg::NUM_CLASSES-1:0]  valid_ff;
   logic [pcls_pkg::COUNT_W-1:0]      frame_cnt_ff;
   logic [pcls_pkg::SUM_W-1:0]        frame_sum_ff;
   logic [pcls_pkg::COUNT_W-1:0]      water_cnt_ff;
   logic [pcls_pkg::SUM_W-1:0]        water_sum_ff;

   entry_type                         class_mem_ff [pcls_pkg::NUM_CLASSES];
   entry_type                         mem_rdata_ff;

   logic [pcls_pkg::CLASS_AW-1:0]     rd_addr;
   logic [pcls_pkg::CLASS_AW-1:0]     job_addr;
   logic                              mem_we;
   entry_type                         cur_entry;
   entry_type                         upd_entry;
   entry_type                         read_entry;
   logic                              div_start;
   logic [pcls_pkg::SUM_W-1:0]        div_dividend;
   logic [pcls_pkg::COUNT_W-1:0]      div_divisor;
   logic                              div_done;
   logic [pcls_pkg::SUM_W-1:0]        div_quotient;

   assign rd_addr  = head_job.class_id[pcls_pkg::CLASS_AW-1:0];
   assign job_addr = job_ff.class_id[pcls_pkg::CLASS_AW-1:0];
   assign pop      = (state_ff == ST_IDLE) && !queue_empty;

   // Class store memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         class_mem_ff[job_addr] <= upd_entry;
      end
      mem_rdata_ff <= class_mem_ff[rd_addr];
   end

   // An entry never written since the last clear reads as zero.
   always_comb begin
      cur_entry = valid_ff[job_addr] ? mem_rdata_ff : '0;
      upd_entry = cur_entry;
      if (cur_entry.count < pcls_pkg::MAX_COUNT) begin
         upd_entry.count = cur_entry.count + 1'b1;
         upd_entry.sum   = cur_entry.sum + pcls_pkg::SUM_W'(job_ff.luma);
      end
      if (job_ff.luma > cur_entry.max) begin
         upd_entry.max = job_ff.luma;
      end
      read_entry = pcls_pkg::class_in_range(job_ff.class_id) ? cur_entry : '0;
   end

   assign mem_we = (state_ff == ST_PIX_RD) && job_ff.acc_class;

   // Mean divider launch: frame and water reads start on pop, class reads after the fetch.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = read_entry.sum;
      div_divisor  = read_entry.count;
      if (state_ff == ST_CLS_RD) begin
         div_start = 1'b1;
      end else if (pop && (head_job.func == pcls_pkg::FUNC_READ_FRAME)) begin
         div_start    = 1'b1;
         div_dividend = frame_sum_ff;
         div_divisor  = frame_cnt_ff;
      end else if (pop && (head_job.func == pcls_pkg::FUNC_READ_WATER)) begin
         div_start    = 1'b1;
         div_dividend = water_sum_ff;
         div_divisor  = water_cnt_ff;
      end
   end

   pcls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequencer with the totals, the valid bits and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         frame_cnt_ff <= '0;
         frame_sum_ff <= '0;
         water_cnt_ff <= '0;
         water_sum_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  job_ff <= head_job;
                  case (head_job.func)
                     pcls_pkg::FUNC_PIXEL: begin
                        if (frame_cnt_ff < pcls_pkg::MAX_COUNT) begin
                           frame_cnt_ff <= frame_cnt_ff + 1'b1;
                           frame_sum_ff <= frame_sum_ff + pcls_pkg::SUM_W'(head_job.luma);
                        end
                        if (head_job.water && (water_cnt_ff < pcls_pkg::MAX_COUNT)) begin
                           water_cnt_ff <= water_cnt_ff + 1'b1;
                           water_sum_ff <= water_sum_ff + pcls_pkg::SUM_W'(head_job.luma);
                        end
                        rsp_valid_ff <= 1'b0;
                        state_ff     <= ST_PIX_RD;
                     end
                     pcls_pkg::FUNC_READ_CLASS: begin
                        rsp_valid_ff <= 1'b0;
                        state_ff     <= ST_CLS_RD;
                     end
                     pcls_pkg::FUNC_READ_FRAME: begin
                        pend_ff.count <= frame_cnt_ff;
                        pend_ff.sum   <= frame_sum_ff;
                        pend_ff.max   <= '0;
                        rsp_valid_ff  <= 1'b0;
                        state_ff      <= ST_DIV;
                     end
                     pcls_pkg::FUNC_READ_WATER: begin
                        pend_ff.count <= water_cnt_ff;
                        pend_ff.sum   <= water_sum_ff;
                        pend_ff.max   <= '0;
                        rsp_valid_ff  <= 1'b0;
                        state_ff      <= ST_DIV;
                     end
                     pcls_pkg::FUNC_CLEAR: begin
                        valid_ff     <= '0;
                        frame_cnt_ff <= '0;
                        frame_sum_ff <= '0;
                        water_cnt_ff <= '0;
                        water_sum_ff <= '0;
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= '0;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= '0;
                     end
                  endcase
               end else begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_PIX_RD: begin
               if (job_ff.acc_class) begin
                  valid_ff[job_addr] <= 1'b1;
               end
               rsp_valid_ff           <= 1'b1;
               rsp_data_ff.pixel_luma <= job_ff.luma;
               rsp_data_ff.is_water   <= job_ff.water;
               rsp_data_ff.count      <= '0;
               rsp_data_ff.luma_sum   <= '0;
               rsp_data_ff.luma_max   <= '0;
               rsp_data_ff.mean_luma  <= '0;
               state_ff               <= ST_IDLE;
            end
            ST_CLS_RD: begin
               pend_ff      <= read_entry;
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_DIV;
            end
            ST_DIV: begin
               rsp_valid_ff <= div_done;
               if (div_done) begin
                  rsp_data_ff.pixel_luma <= '0;
                  rsp_data_ff.is_water   <= 1'b0;
                  rsp_data_ff.count      <= pend_ff.count;
                  rsp_data_ff.luma_sum   <= pend_ff.sum;
                  rsp_data_ff.luma_max   <= pend_ff.max;
                  rsp_data_ff.mean_luma  <= div_quotient[pcls_pkg::LUMA_W-1:0];
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Totals never pass the saturation limit, and water is a subset of the frame.
   a_frame_saturates: assert property (@(posedge clock) disable iff (reset)
      frame_cnt_ff <= pcls_pkg::MAX_COUNT)
      else $error("frame count beyond saturation limit");

   a_water_subset: assert property (@(posedge clock) disable iff (reset)
      water_cnt_ff <= frame_cnt_ff)
      else $error("water count exceeds frame count");

   a_pixel_one_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX_RD) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("pixel job did not produce its result");

endmodule

/* tb/per_class_luma_statistics_test.sv */
// Self-checking testbench for the per-class luma statistics block.
`timescale 1ns / 1ps

module per_class_luma_statistics_test;

   // Cycles with no beat in either direction before the run is declared hung.
   localparam int STALL_LIMIT  = 2000;
   // Quiet time after the last result, to catch any stray result beat.
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS  = 140;
   localparam int NUM_PHASES   = 6;

   // The three func codes that the block must ignore.
   localparam logic [pcls_pkg::FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
   localparam logic [pcls_pkg::FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
   localparam logic [pcls_pkg::FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

   // Directed rows either take their result from the table or from the predictor.
   localparam logic PREDICTED = 1'b0;
   localparam logic TYPED     = 1'b1;

   typedef struct packed {
      logic                        ids_on;
      logic [pcls_pkg::ID_W-1:0]   water_id;
      logic [pcls_pkg::CHAN_W-1:0] margin_br;
      logic [pcls_pkg::CHAN_W-1:0] blue_min;
      logic [pcls_pkg::CHAN_W-1:0] slack_g;
   } cfg_type;

   typedef struct packed {
      pcls_pkg::req_type           item;
      logic                        typed;
      logic [pcls_pkg::LUMA_W-1:0] luma;
      logic                        water;
   } row_type;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            start     = 1'b0;
   logic                            busy;
   pcls_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   pcls_pkg::rsp_type               rsp_data;
   logic                            csr_we    = 1'b0;
   logic [pcls_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pcls_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Predicted statistics and the register settings they depend on.
   logic [pcls_pkg::COUNT_W-1:0] cls_count [pcls_pkg::NUM_CLASSES];
   logic [pcls_pkg::SUM_W-1:0]   cls_sum   [pcls_pkg::NUM_CLASSES];
   logic [pcls_pkg::LUMA_W-1:0]  cls_peak  [pcls_pkg::NUM_CLASSES];
   logic [pcls_pkg::COUNT_W-1:0] frame_count;
   logic [pcls_pkg::SUM_W-1:0]   frame_sum;
   logic [pcls_pkg::COUNT_W-1:0] water_count;
   logic [pcls_pkg::SUM_W-1:0]   water_sum;
   cfg_type                      cfg;

   pcls_pkg::rsp_type pending_stats [$];
   row_type           script [$];
   int                mismatches   = 0;
   int                stall_cycles = 0;
   int                steady_left  = 0;

   per_class_luma_statistics DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Zero every store of the prediction, as a clear beat or reset does.
   function automatic void clear_stats();
      for (int i = 0; i < pcls_pkg::NUM_CLASSES; i++) begin
         cls_count[i] = '0;
         cls_sum[i]   = '0;
         cls_peak[i]  = '0;
      end
      frame_count = '0;
      frame_sum   = '0;
      water_count = '0;
      water_sum   = '0;
   endfunction

   // Counts stop at the pixel limit, and the sum stops with them.
   function automatic void add_luma(inout logic [pcls_pkg::COUNT_W-1:0] cnt,
                                    inout logic [pcls_pkg::SUM_W-1:0] sum,
                                    input logic [pcls_pkg::LUMA_W-1:0] luma);
      if (cnt < pcls_pkg::MAX_COUNT) begin
         cnt = cnt + 1'b1;
         sum = sum + luma;
      end
   endfunction

   function automatic logic [pcls_pkg::LUMA_W-1:0] average(
      input logic [pcls_pkg::SUM_W-1:0] sum,
      input logic [pcls_pkg::COUNT_W-1:0] cnt);
      return (cnt == 0) ? '0 : pcls_pkg::LUMA_W'(sum / cnt);
   endfunction

   // Works out the result of one beat and updates the predicted stores.
   function automatic pcls_pkg::rsp_type predict_stats(input pcls_pkg::req_type item);
      pcls_pkg::rsp_type           res;
      int unsigned                 r, g, b;
      logic [pcls_pkg::LUMA_W-1:0] luma;
      logic                        blue_dom, water;
      res = '0;
      r = item.red;
      g = item.green;
      b = item.blue;
      case (item.func)
         pcls_pkg::FUNC_PIXEL: begin
            luma = pcls_pkg::LUMA_W'(pcls_pkg::LUMA_R * r + pcls_pkg::LUMA_G * g
                                     + pcls_pkg::LUMA_B * b);
            blue_dom = (b >= r + cfg.margin_br) && (b > cfg.blue_min) &&
                       (b + cfg.slack_g >= g);
            water = (cfg.ids_on && item.class_id == cfg.water_id) ||
                    ((!cfg.ids_on || item.class_id == 0) && blue_dom);
            add_luma(frame_count, frame_sum, luma);
            if (cfg.ids_on && item.class_id < pcls_pkg::NUM_CLASSES) begin
               add_luma(cls_count[item.class_id], cls_sum[item.class_id], luma);
               if (luma > cls_peak[item.class_id])
                  cls_peak[item.class_id] = luma;
            end
            if (water)
               add_luma(water_count, water_sum, luma);
            res.pixel_luma = luma;
            res.is_water   = water;
         end
         pcls_pkg::FUNC_READ_CLASS: begin
            if (item.class_id < pcls_pkg::NUM_CLASSES) begin
               res.count     = cls_count[item.class_id];
               res.luma_sum  = cls_sum[item.class_id];
               res.luma_max  = cls_peak[item.class_id];
               res.mean_luma = average(cls_sum[item.class_id], cls_count[item.class_id]);
            end
         end
         pcls_pkg::FUNC_READ_FRAME: begin
            res.count     = frame_count;
            res.luma_sum  = frame_sum;
            res.mean_luma = average(frame_sum, frame_count);
         end
         pcls_pkg::FUNC_READ_WATER: begin
            res.count     = water_count;
            res.luma_sum  = water_sum;
            res.mean_luma = average(water_sum, water_count);
         end
         pcls_pkg::FUNC_CLEAR: begin
            clear_stats();
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic logic [pcls_pkg::CHAN_W-1:0] clamp_byte(input int v);
      if (v < 0)
         return '0;
      if (v > 255)
         return '1;
      return pcls_pkg::CHAN_W'(v);
   endfunction

   // Mostly pixels, many of them close to the water thresholds, on a few busy classes.
   function automatic pcls_pkg::req_type random_item();
      pcls_pkg::req_type item;
      int unsigned       pick;
      int                b;
      pick = $urandom_range(0, 99);
      if (pick < 72)
         item.func = pcls_pkg::FUNC_PIXEL;
      else if (pick < 84)
         item.func = pcls_pkg::FUNC_READ_CLASS;
      else if (pick < 89)
         item.func = pcls_pkg::FUNC_READ_FRAME;
      else if (pick < 94)
         item.func = pcls_pkg::FUNC_READ_WATER;
      else if (pick < 95)
         item.func = pcls_pkg::FUNC_CLEAR;
      else
         item.func = pcls_pkg::FUNC_W'($urandom_range(FUNC_SPARE_A, FUNC_SPARE_C));

      if ($urandom_range(0, 2) == 0) begin
         item.red   = pcls_pkg::CHAN_W'($urandom_range(0, 255));
         item.green = pcls_pkg::CHAN_W'($urandom_range(0, 255));
         item.blue  = pcls_pkg::CHAN_W'($urandom_range(0, 255));
      end else begin
         case ($urandom_range(0, 3))
            0:       b = int'(cfg.blue_min);
            1:       b = int'(cfg.blue_min) + 1;
            2:       b = 255;
            default: b = int'($urandom_range(0, 255));
         endcase
         item.blue  = clamp_byte(b);
         item.red   = clamp_byte(b - int'(cfg.margin_br) + int'($urandom_range(0, 3)) - 2);
         item.green = clamp_byte(b + int'(cfg.slack_g) + int'($urandom_range(0, 3)) - 2);
      end

      case ($urandom_range(0, 9))
         0, 1:       item.class_id = '0;
         2:          item.class_id = cfg.water_id;
         3, 4, 5, 6: item.class_id = pcls_pkg::ID_W'($urandom_range(1, 6));
         default:    item.class_id = pcls_pkg::ID_W'($urandom_range(0, 255));
      endcase
      return item;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a run with no gaps at all.
   function automatic int pick_gap();
      int unsigned p;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      p = $urandom_range(0, 99);
      if (p < 2) begin
         steady_left = $urandom_range(20, 60);
         return 0;
      end
      if (p < 40)
         return 0;
      if (p < 85)
         return $urandom_range(1, 3);
      if (p < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_row(input logic [pcls_pkg::FUNC_W-1:0] func, input int r, input int g,
                          input int b, input int id, input logic typed, input int luma,
                          input logic water);
      row_type row;
      row.item.func     = func;
      row.item.red      = pcls_pkg::CHAN_W'(r);
      row.item.green    = pcls_pkg::CHAN_W'(g);
      row.item.blue     = pcls_pkg::CHAN_W'(b);
      row.item.class_id = pcls_pkg::ID_W'(id);
      row.typed         = typed;
      row.luma          = pcls_pkg::LUMA_W'(luma);
      row.water         = water;
      script = {script, row};
   endtask

   // Holds one beat on the request port until it is taken, then records its result.
   task automatic issue(input pcls_pkg::req_type item, input logic typed,
                        input pcls_pkg::rsp_type want);
      int gap;
      req_data <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (typed) begin
         void'(predict_stats(item));
         pending_stats = {pending_stats, want};
      end else begin
         pending_stats = {pending_stats, predict_stats(item)};
      end
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Every beat gives a result, so an empty queue means the block is idle.
   task automatic settle();
      start <= 1'b0;
      while (pending_stats.size() != 0)
         @(posedge clock);
   endtask

   // Writes all five registers back to back with the write enable held high.
   task automatic program_regs(input cfg_type setting);
      csr_we    <= 1'b1;
      csr_index <= pcls_pkg::CSR_IDS_ENABLED;
      csr_wdata <= pcls_pkg::CSR_DATA_W'(setting.ids_on);
      @(posedge clock);
      csr_index <= pcls_pkg::CSR_FAR_WATER_ID;
      csr_wdata <= setting.water_id;
      @(posedge clock);
      csr_index <= pcls_pkg::CSR_BLUE_OVER_RED;
      csr_wdata <= setting.margin_br;
      @(posedge clock);
      csr_index <= pcls_pkg::CSR_BLUE_FLOOR;
      csr_wdata <= setting.blue_min;
      @(posedge clock);
      csr_index <= pcls_pkg::CSR_GREEN_SLACK;
      csr_wdata <= setting.slack_g;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg = setting;
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // Compare each result beat with the oldest prediction.
   always @(posedge clock) begin
      pcls_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result beat with nothing expected", $time);
         end else begin
            want = pending_stats.pop_front();
            check_field("pixel_luma", want.pixel_luma, rsp_data.pixel_luma);
            check_field("is_water", want.is_water, rsp_data.is_water);
            check_field("count", want.count, rsp_data.count);
            check_field("luma_sum", want.luma_sum, rsp_data.luma_sum);
            check_field("luma_max", want.luma_max, rsp_data.luma_max);
            check_field("mean_luma", want.mean_luma, rsp_data.mean_luma);
         end
      end
   end

   // Watchdog on cycles in which no beat moves in either direction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("** per_class_luma_statistics: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      cfg_type           plan [NUM_PHASES];
      pcls_pkg::rsp_type want;
      cfg = '{1'b1, pcls_pkg::RST_FAR_WATER_ID, pcls_pkg::RST_BLUE_OVER_RED,
              pcls_pkg::RST_BLUE_FLOOR, pcls_pkg::RST_GREEN_SLACK};
      clear_stats();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset register values.
      add_row(pcls_pkg::FUNC_READ_FRAME, 0, 0, 0, 0, TYPED, 0, 0);
      add_row(pcls_pkg::FUNC_READ_WATER, 255, 255, 255, 255, TYPED, 0, 0);
      add_row(pcls_pkg::FUNC_READ_CLASS, 0, 0, 0, 255, TYPED, 0, 0);
      // White and black on an ordinary class.
      add_row(pcls_pkg::FUNC_PIXEL, 255, 255, 255, 7, TYPED, 2550000, 0);
      add_row(pcls_pkg::FUNC_PIXEL, 0, 0, 0, 7, TYPED, 0, 0);
      // Pure blue on the open id is water; the far-water id is water whatever its color.
      add_row(pcls_pkg::FUNC_PIXEL, 0, 0, 255, 0, TYPED, 184110, 1);
      add_row(pcls_pkg::FUNC_PIXEL, 255, 255, 0, 200, TYPED, 2365890, 1);
      // Pure blue on a claimed id is not water.
      add_row(pcls_pkg::FUNC_PIXEL, 0, 0, 255, 5, PREDICTED, 0, 0);
      // Margin and green slack met exactly with blue above its floor, then each one missed by one step.
      add_row(pcls_pkg::FUNC_PIXEL, 20, 30, 26, 0, PREDICTED, 0, 0);
      add_row(pcls_pkg::FUNC_PIXEL, 21, 30, 26, 0, PREDICTED, 0, 0);
      add_row(pcls_pkg::FUNC_PIXEL, 20, 31, 26, 0, PREDICTED, 0, 0);
      add_row(pcls_pkg::FUNC_PIXEL, 0, 0, 22, 0, PREDICTED, 0, 0);
      add_row(pcls_pkg::FUNC_PIXEL, 255, 0, 0, 255, PREDICTED, 0, 0);
      add_row(pcls_pkg::FUNC_READ_CLASS, 0, 0, 0, 7, PREDICTED, 0, 0);
      add_row(pcls_pkg::FUNC_READ_CLASS, 0, 0, 0, 0, PREDICTED, 0, 0);
      add_row(pcls_pkg::FUNC_READ_CLASS, 0, 0, 0, 200, PREDICTED, 0, 0);
      add_row(pcls_pkg::FUNC_READ_CLASS, 0, 0, 0, 255, PREDICTED, 0, 0);
      add_row(pcls_pkg::FUNC_READ_FRAME, 0, 0, 0, 0, PREDICTED, 0, 0);
      add_row(pcls_pkg::FUNC_READ_WATER, 0, 0, 0, 0, PREDICTED, 0, 0);
      // Unused codes change nothing and answer with zeros.
      add_row(FUNC_SPARE_A, 255, 255, 255, 7, TYPED, 0, 0);
      add_row(FUNC_SPARE_B, 0, 0, 255, 0, TYPED, 0, 0);
      add_row(FUNC_SPARE_C, 255, 255, 0, 200, TYPED, 0, 0);
      // A clear empties every store.
      add_row(pcls_pkg::FUNC_CLEAR, 255, 255, 255, 255, TYPED, 0, 0);
      add_row(pcls_pkg::FUNC_READ_FRAME, 0, 0, 0, 0, TYPED, 0, 0);
      add_row(pcls_pkg::FUNC_READ_CLASS, 0, 0, 0, 7, TYPED, 0, 0);

      foreach (script[i]) begin
         want            = '0;
         want.pixel_luma = script[i].luma;
         want.is_water   = script[i].water;
         issue(script[i].item, script[i].typed, want);
      end

      // Random phases, each under its own register settings.
      plan[0] = '{1'b1, pcls_pkg::RST_FAR_WATER_ID, pcls_pkg::RST_BLUE_OVER_RED,
                  pcls_pkg::RST_BLUE_FLOOR, pcls_pkg::RST_GREEN_SLACK};
      plan[1] = '{1'b0, pcls_pkg::ID_W'($urandom_range(1, 255)), 8'd6, 8'd22, 8'd4};
      plan[2] = '{1'b1, 8'd0, 8'd0, 8'd0, 8'd0};
      plan[3] = '{1'b1, 8'd255, 8'd255, 8'd255, 8'd255};
      plan[4] = '{1'b0, 8'd0, 8'd0, 8'd0, 8'd255};
      plan[5] = '{1'($urandom_range(0, 1)), pcls_pkg::ID_W'($urandom_range(0, 255)),
                  pcls_pkg::CHAN_W'($urandom_range(0, 40)),
                  pcls_pkg::CHAN_W'($urandom_range(0, 120)),
                  pcls_pkg::CHAN_W'($urandom_range(0, 40))};
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         program_regs(plan[ph]);
         repeat (PHASE_ITEMS) issue(random_item(), PREDICTED, '0);
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_stats.size() == 0)
         $display("** per_class_luma_statistics: PASSED **");
      else
         $display("** per_class_luma_statistics: FAILED **");
      $finish;
   end

endmodule

/* per_class_luma_statistics.f */
hw/rtl/pcls_pkg.sv
hw/rtl/pcls_front.sv
hw/rtl/pcls_queue.sv
hw/rtl/pcls_div.sv
hw/rtl/pcls_back.sv
hw/rtl/per_class_luma_statistics.sv
tb/per_class_luma_statistics_test.sv
